FILE: rtl/tcst_pkg.sv
`default_nettype none

package tcst_pkg;

    localparam int unsigned SeqW = 32;
    localparam int unsigned WinW = 16;
    localparam int unsigned LenW = 16;

    localparam int unsigned FlagFinBit = 0;
    localparam int unsigned FlagSynBit = 1;
    localparam int unsigned FlagRstBit = 2;
    localparam int unsigned FlagAckBit = 4;

    typedef enum logic [3:0] {
        ST_CLOSED      = 4'd0,
        ST_SYN_ISSUED  = 4'd1,
        ST_SYN_RCVD    = 4'd2,
        ST_ESTABLISHED = 4'd3,
        ST_FIN_WAIT_1  = 4'd4,
        ST_FIN_WAIT_2  = 4'd5,
        ST_CLOSING     = 4'd6,
        ST_TIME_WAIT   = 4'd7,
        ST_CLOSE_WAIT  = 4'd8,
        ST_LAST_ACK    = 4'd9
    } conn_state_t;

    typedef enum logic [1:0] {
        VERDICT_REJECT  = 2'd0,
        VERDICT_ACCEPT  = 2'd1,
        VERDICT_RST_OK  = 2'd2,
        VERDICT_RST_BAD = 2'd3
    } verdict_t;

    typedef struct packed {
        conn_state_t           state;
        logic [SeqW-1:0]       unacked;
        logic [SeqW-1:0]       next_seq;
        logic [WinW-1:0]       window;
    } endpoint_t;

    typedef struct packed {
        logic                  direction;
        logic [7:0]            seg_flags;
        logic [SeqW-1:0]       seg_seq;
        logic [SeqW-1:0]       seg_ack;
        logic [WinW-1:0]       seg_window;
        logic [LenW-1:0]       seg_length;
    } segment_t;

    // a >= b, modulo 2^32
    function automatic logic sq_geq(input logic [SeqW-1:0] a, input logic [SeqW-1:0] b);
        logic [SeqW-1:0] d;
        d = a - b;
        return ~d[SeqW-1];
    endfunction

    // a <= b, modulo 2^32
    function automatic logic sq_leq(input logic [SeqW-1:0] a, input logic [SeqW-1:0] b);
        logic [SeqW-1:0] d;
        d = a - b;
        return (d == '0) || d[SeqW-1];
    endfunction

    function automatic logic sq_between(input logic [SeqW-1:0] a,
                                        input logic [SeqW-1:0] lo,
                                        input logic [SeqW-1:0] hi);
        return sq_geq(a, lo) && sq_leq(a, hi);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tcst_seg_if.sv
`default_nettype none

interface tcst_seg_if;
    logic                      valid;
    logic                      ready;
    logic                      direction;
    logic [7:0]                seg_flags;
    logic [tcst_pkg::SeqW-1:0] seg_seq;
    logic [tcst_pkg::SeqW-1:0] seg_ack;
    logic [tcst_pkg::WinW-1:0] seg_window;
    logic [tcst_pkg::LenW-1:0] seg_length;

    modport source (
        output valid, direction, seg_flags, seg_seq, seg_ack, seg_window, seg_length,
        input  ready
    );
    modport sink (
        input  valid, direction, seg_flags, seg_seq, seg_ack, seg_window, seg_length,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/tcst_res_if.sv
`default_nettype none

interface tcst_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    logic [3:0] state_zero;
    logic [3:0] state_one;

    modport source (
        output valid, verdict, state_zero, state_one,
        input  ready
    );
    modport sink (
        input  valid, verdict, state_zero, state_one,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/tcp_conn_state_tracker_core.sv
// channel  role    handshake      payload
// seg      sink    valid / ready  direction, seg_flags, seg_seq, seg_ack, seg_window, seg_length
// res      source  valid / ready  verdict, state_zero, state_one
//
// one segment per cycle sustained unless res.ready holds a result back; a result is offered
// once its segment has gone through an input register, the rule logic and a result register
// endpoint records update when a segment moves from the input register to the result register
// rst_n clears both records to closed, zero sequence numbers and zero windows
// a stalled result holds the input register; seg.ready drops only when both stages are full
`default_nettype none

module tcp_conn_state_tracker_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tcst_seg_if.sink    seg,
    tcst_res_if.source  res
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    tcst_pkg::segment_t   in_data_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    tcst_pkg::verdict_t   out_verdict_reg;
    tcst_pkg::conn_state_t out_st0_reg;
    tcst_pkg::conn_state_t out_st1_reg;
    tcst_pkg::endpoint_t  rec0_reg;
    tcst_pkg::endpoint_t  rec1_reg;
    tcst_pkg::endpoint_t  rec0_next;
    tcst_pkg::endpoint_t  rec1_next;

    tcst_pkg::endpoint_t  rcv;
    tcst_pkg::endpoint_t  snd;
    tcst_pkg::endpoint_t  rcv_upd;
    tcst_pkg::endpoint_t  snd_upd;
    tcst_pkg::verdict_t   verdict;
    tcst_pkg::segment_t   seg_data;

    logic                 take;
    logic                 advance;

    assign seg_data = '{direction:  seg.direction,
                        seg_flags:  seg.seg_flags,
                        seg_seq:    seg.seg_seq,
                        seg_ack:    seg.seg_ack,
                        seg_window: seg.seg_window,
                        seg_length: seg.seg_length};

    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign seg.ready = !in_valid_reg || advance;
    assign take      = seg.valid && seg.ready;

    // receiver role picked by direction
    assign rcv = in_data_reg.direction ? rec1_reg : rec0_reg;
    assign snd = in_data_reg.direction ? rec0_reg : rec1_reg;

    tcst_rules u_rules (
        .seg     (in_data_reg),
        .rcv     (rcv),
        .snd     (snd),
        .rcv_upd (rcv_upd),
        .snd_upd (snd_upd),
        .verdict (verdict)
    );

    assign rec0_next = in_data_reg.direction ? snd_upd : rcv_upd;
    assign rec1_next = in_data_reg.direction ? rcv_upd : snd_upd;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rec0_reg      <= '{state: tcst_pkg::ST_CLOSED, unacked: '0, next_seq: '0,
                               window: '0};
            rec1_reg      <= '{state: tcst_pkg::ST_CLOSED, unacked: '0, next_seq: '0,
                               window: '0};
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                rec0_reg <= rec0_next;
                rec1_reg <= rec1_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg <= seg_data;
        end
        if (advance)
        begin
            out_verdict_reg <= verdict;
            out_st0_reg     <= rec0_next.state;
            out_st1_reg     <= rec1_next.state;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.verdict    = out_verdict_reg;
    assign res.state_zero = out_st0_reg;
    assign res.state_one  = out_st1_reg;

    // records move only with a transaction through the rule logic
    a_rec_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(rec0_reg) && $stable(rec1_reg)))
        else $error("endpoint record changed without a segment");

    // a rejected reset leaves both records as they were
    a_rst_bad_no_change : assert property (@(posedge clk) disable iff (!rst_n)
        advance && verdict == tcst_pkg::VERDICT_RST_BAD
        |=> (rec0_reg == $past(rec0_reg)) && (rec1_reg == $past(rec1_reg)))
        else $error("rejected reset altered a record");

    // an accepted reset closes both records
    a_rst_ok_closed : assert property (@(posedge clk) disable iff (!rst_n)
        advance && verdict == tcst_pkg::VERDICT_RST_OK
        |=> rec0_reg.state == tcst_pkg::ST_CLOSED && rec1_reg.state == tcst_pkg::ST_CLOSED)
        else $error("accepted reset left a record open");

    // reported states track the records just written
    a_report_matches : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res.valid && res.state_zero == rec0_reg.state
                    && res.state_one == rec1_reg.state)
        else $error("reported state differs from record");

    // an empty input stage always takes a transaction
    a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> seg.ready)
        else $error("input stage empty but not ready");

endmodule

`default_nettype wire

FILE: rtl/tcst_rules.sv
`default_nettype none

module tcst_rules (
    input  tcst_pkg::segment_t  seg,
    input  tcst_pkg::endpoint_t rcv,
    input  tcst_pkg::endpoint_t snd,
    output tcst_pkg::endpoint_t rcv_upd,
    output tcst_pkg::endpoint_t snd_upd,
    output tcst_pkg::verdict_t  verdict
);

    logic                      fin;
    logic                      syn;
    logic                      rst;
    logic                      ackf;
    logic [tcst_pkg::SeqW-1:0] seq_end;
    logic [tcst_pkg::SeqW-1:0] rcv_lo;
    logic [tcst_pkg::SeqW-1:0] rcv_hi;
    logic [tcst_pkg::SeqW-1:0] snd_hi;
    logic                      rst_ok;
    logic                      in_win;
    logic                      ack_ok;
    logic                      ack_exact;

    assign fin  = seg.seg_flags[tcst_pkg::FlagFinBit];
    assign syn  = seg.seg_flags[tcst_pkg::FlagSynBit];
    assign rst  = seg.seg_flags[tcst_pkg::FlagRstBit];
    assign ackf = seg.seg_flags[tcst_pkg::FlagAckBit];

    assign seq_end = seg.seg_seq + {{(tcst_pkg::SeqW-tcst_pkg::LenW){1'b0}}, seg.seg_length};
    assign rcv_lo  = rcv.unacked + 32'd1;
    assign rcv_hi  = rcv_lo + {{(tcst_pkg::SeqW-tcst_pkg::WinW){1'b0}}, rcv.window};
    assign snd_hi  = snd.unacked + {{(tcst_pkg::SeqW-tcst_pkg::WinW){1'b0}}, snd.window}
                     + 32'd1;

    // a receiver whose own syn is out checks the ack, any other state checks the window
    assign rst_ok = (rcv.state == tcst_pkg::ST_SYN_ISSUED) ? (seg.seg_ack == rcv_lo)
                  : tcst_pkg::sq_between(seg.seg_seq, rcv_lo, rcv_hi);

    assign in_win = tcst_pkg::sq_between(seg.seg_seq, snd.unacked, snd_hi)
                 && tcst_pkg::sq_between(seq_end, snd.unacked, snd_hi);

    assign ack_ok    = tcst_pkg::sq_between(seg.seg_ack, rcv.unacked, rcv.next_seq);
    assign ack_exact = (seg.seg_ack == rcv.next_seq);

    always_comb
    begin
        rcv_upd = rcv;
        snd_upd = snd;
        verdict = tcst_pkg::VERDICT_REJECT;
        if (rst)
        begin
            if (rst_ok)
            begin
                rcv_upd.state = tcst_pkg::ST_CLOSED;
                snd_upd.state = tcst_pkg::ST_CLOSED;
                verdict       = tcst_pkg::VERDICT_RST_OK;
            end
            else
            begin
                verdict = tcst_pkg::VERDICT_RST_BAD;
            end
        end
        else
        begin
            case (rcv.state)
                tcst_pkg::ST_CLOSED:
                begin
                    if (!ackf && syn)
                    begin
                        snd_upd.unacked  = seg.seg_seq;
                        snd_upd.next_seq = seq_end;
                        snd_upd.state    = tcst_pkg::ST_SYN_ISSUED;
                        rcv_upd.window   = seg.seg_window;
                        rcv_upd.state    = tcst_pkg::ST_SYN_RCVD;
                        verdict          = tcst_pkg::VERDICT_ACCEPT;
                    end
                end
                tcst_pkg::ST_SYN_ISSUED:
                begin
                    if (ackf)
                    begin
                        if (ack_ok && !(syn && snd.state == tcst_pkg::ST_ESTABLISHED))
                        begin
                            if (syn)
                            begin
                                snd_upd.unacked = seg.seg_seq;
                                snd_upd.state   = tcst_pkg::ST_SYN_ISSUED;
                            end
                            snd_upd.next_seq = seq_end;
                            rcv_upd.unacked  = seg.seg_ack;
                            rcv_upd.window   = seg.seg_window;
                            rcv_upd.state    = tcst_pkg::ST_ESTABLISHED;
                            verdict          = tcst_pkg::VERDICT_ACCEPT;
                        end
                    end
                    else if (syn)
                    begin
                        snd_upd.unacked  = seg.seg_seq;
                        snd_upd.next_seq = seq_end;
                        snd_upd.state    = tcst_pkg::ST_SYN_ISSUED;
                        rcv_upd.window   = seg.seg_window;
                        rcv_upd.state    = tcst_pkg::ST_SYN_RCVD;
                        verdict          = tcst_pkg::VERDICT_ACCEPT;
                    end
                end
                tcst_pkg::ST_ESTABLISHED:
                begin
                    if (in_win && !syn && !(ackf && !ack_ok))
                    begin
                        if (ackf)
                        begin
                            rcv_upd.unacked = seg.seg_ack;
                            rcv_upd.window  = seg.seg_window;
                        end
                        if (fin)
                        begin
                            rcv_upd.state = tcst_pkg::ST_CLOSE_WAIT;
                            snd_upd.state = tcst_pkg::ST_FIN_WAIT_1;
                        end
                        snd_upd.unacked  = seg.seg_seq;
                        snd_upd.next_seq = seq_end;
                        verdict          = tcst_pkg::VERDICT_ACCEPT;
                    end
                end
                tcst_pkg::ST_FIN_WAIT_1:
                begin
                    if (in_win && !syn)
                    begin
                        // fin state change stays even when the ack check fails
                        if (fin)
                        begin
                            rcv_upd.state = tcst_pkg::ST_CLOSING;
                            snd_upd.state = tcst_pkg::ST_LAST_ACK;
                        end
                        if (!(ackf && !ack_exact))
                        begin
                            if (ackf)
                            begin
                                rcv_upd.state   = fin ? tcst_pkg::ST_TIME_WAIT
                                                      : tcst_pkg::ST_FIN_WAIT_2;
                                rcv_upd.unacked = seg.seg_ack;
                                rcv_upd.window  = seg.seg_window;
                            end
                            snd_upd.unacked  = seg.seg_seq;
                            snd_upd.next_seq = seq_end;
                            verdict          = tcst_pkg::VERDICT_ACCEPT;
                        end
                    end
                end
                tcst_pkg::ST_FIN_WAIT_2:
                begin
                    if (in_win && !syn && !(ackf && !ack_exact))
                    begin
                        if (fin)
                        begin
                            rcv_upd.state = tcst_pkg::ST_TIME_WAIT;
                            snd_upd.state = tcst_pkg::ST_LAST_ACK;
                        end
                        snd_upd.unacked  = seg.seg_seq;
                        snd_upd.next_seq = seq_end;
                        rcv_upd.unacked  = seg.seg_ack;
                        rcv_upd.window   = seg.seg_window;
                        verdict          = tcst_pkg::VERDICT_ACCEPT;
                    end
                end
                tcst_pkg::ST_CLOSING:
                begin
                    if (in_win && !syn && !(ackf && !ack_exact))
                    begin
                        snd_upd.unacked  = seg.seg_seq;
                        snd_upd.next_seq = seq_end;
                        rcv_upd.state    = tcst_pkg::ST_TIME_WAIT;
                        verdict          = tcst_pkg::VERDICT_ACCEPT;
                    end
                end
                tcst_pkg::ST_CLOSE_WAIT:
                begin
                    if (seg.seg_seq == snd.next_seq && seg.seg_length == '0 && ackf && ack_ok)
                    begin
                        rcv_upd.unacked = seg.seg_ack;
                        rcv_upd.window  = seg.seg_window;
                        verdict         = tcst_pkg::VERDICT_ACCEPT;
                    end
                end
                tcst_pkg::ST_LAST_ACK:
                begin
                    if (seg.seg_seq == snd.next_seq && !(ackf && !ack_exact))
                    begin
                        rcv_upd.state = tcst_pkg::ST_CLOSED;
                        snd_upd.state = tcst_pkg::ST_CLOSED;
                        verdict       = tcst_pkg::VERDICT_ACCEPT;
                    end
                end
                default:
                begin
                    verdict = tcst_pkg::VERDICT_REJECT;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
